// ===== src/assert_macros.svh =====
// assertion helpers included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, switched off while rst_ni is low
`define CSWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the condition, on clk_i, off during reset
`define CSWC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/cswc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cswc_pkg
// Types and constants of the clock skew warp checker: the round request,
// the verdict and the widths of the counter values.
// ----------------------------------------------------------------------------
package cswc_pkg;

  localparam int unsigned CntW  = 64;
  localparam int unsigned WarpW = 63;

  // threshold after reset, in counter cycles
  localparam logic [WarpW-1:0] WarpResetLimit = WarpW'(200);

  // one measurement round
  typedef struct packed {
    logic [CntW-1:0] ref_before;
    logic [CntW-1:0] remote_sample;
    logic [CntW-1:0] ref_after;
    logic            last_round;
  } in_item_t;

  // verdict with the collected statistics
  typedef struct packed {
    logic               check_passed;
    logic [WarpW-1:0]   worst_warp;
    logic signed [CntW-1:0] min_trip_offset;
    logic [CntW-1:0]    least_round_trip;
  } out_item_t;

endpackage
`default_nettype wire

// ===== src/clock_skew_warp_checker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// datapath: a round is registered in the input register at acceptance and
//   evaluated there; a last round's verdict is then registered in the result register
// throughput: one round per cycle; the single result register only holds up
//   a last round while an earlier verdict has not been taken
// reset: running statistics cleared, threshold set to 200, no result pending
// ----------------------------------------------------------------------------
// clock_skew_warp_checker_top
// Checks remote counter samples against reference windows, tracks the worst
// warp, the least round trip and its offset, and reports on the last round.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clock_skew_warp_checker_top
  import cswc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // round requests
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_item_i,
  // verdicts
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_o,
  // threshold register
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [WarpW-1:0] cfg_wdata_i
);

  logic [WarpW-1:0] max_allowed_warp_q;

  logic     s1_valid_q;
  in_item_t s1_q;
  logic     s1_adv;
  logic     s1_adv_last;

  logic [WarpW-1:0] run_max_warp_q, run_max_warp_d;
  logic [CntW-1:0]  run_min_trip_q, run_min_trip_d;
  logic [CntW-1:0]  run_offset_q,   run_offset_d;

  logic      out_valid_q;
  out_item_t out_q;

  logic [CntW-1:0]  trip;
  logic [CntW-1:0]  diff;
  logic [WarpW-1:0] warp;
  logic [CntW-1:0]  offset;

  // threshold register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_allowed_warp_q <= WarpResetLimit;
    end else if (cfg_valid_i) begin
      max_allowed_warp_q <= cfg_wdata_i;
    end
  end

  // stage one drains unless a verdict has nowhere to go
  assign s1_adv      = s1_valid_q && (!s1_q.last_round || !out_valid_q || out_ready_i);
  assign s1_adv_last = s1_adv && s1_q.last_round;
  assign in_ready_o  = !s1_valid_q || s1_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_item_i;
    end
  end

  // round trip, warp outside the window and offset from the midpoint
  assign trip = s1_q.ref_after - s1_q.ref_before;

  always_comb begin
    priority if (s1_q.remote_sample < s1_q.ref_before) begin
      diff = s1_q.ref_before - s1_q.remote_sample;
    end else if (s1_q.remote_sample > s1_q.ref_after) begin
      diff = s1_q.remote_sample - s1_q.ref_after;
    end else begin
      diff = '0;
    end
  end

  // saturate at the top of the 63 bit range
  assign warp   = diff[CntW-1] ? {WarpW{1'b1}} : diff[WarpW-1:0];
  assign offset = s1_q.remote_sample - s1_q.ref_before - {1'b0, trip[CntW-1:1]};

  // running statistics including the current round
  always_comb begin
    run_max_warp_d = (warp > run_max_warp_q) ? warp : run_max_warp_q;
    run_min_trip_d = run_min_trip_q;
    run_offset_d   = run_offset_q;
    if (trip < run_min_trip_q) begin
      run_min_trip_d = trip;
      run_offset_d   = offset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_max_warp_q <= '0;
      run_min_trip_q <= '1;
      run_offset_q   <= '0;
    end else if (s1_adv_last) begin
      run_max_warp_q <= '0;
      run_min_trip_q <= '1;
      run_offset_q   <= '0;
    end else if (s1_adv) begin
      run_max_warp_q <= run_max_warp_d;
      run_min_trip_q <= run_min_trip_d;
      run_offset_q   <= run_offset_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_last) begin
      out_q.check_passed     <= (run_max_warp_d <= max_allowed_warp_q);
      out_q.worst_warp       <= run_max_warp_d;
      out_q.min_trip_offset  <= run_offset_d;
      out_q.least_round_trip <= run_min_trip_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // checks
  `CSWC_ASSERT(a_stall_only_on_full_verdict,
    !in_ready_o |-> (s1_valid_q && s1_q.last_round && out_valid_q && !out_ready_i),
    "input stalled without a blocked verdict")
  `CSWC_ASSERT(a_verdict_from_last_round,
    $rose(out_valid_o) |-> $past(s1_adv_last),
    "verdict raised without a last round")
  `CSWC_ASSERT_NEXT(a_stats_cleared_after_verdict, s1_adv_last,
    (run_max_warp_q == '0 && run_min_trip_q == '1 && run_offset_q == '0),
    "running statistics not cleared after a verdict")

endmodule
`default_nettype wire
